// ===== rtl/eight_bit_alu_with_flags_defines.svh =====
// Assertion macros shared by the ALU checker.
`ifndef EIGHT_BIT_ALU_WITH_FLAGS_DEFINES_SVH
`define EIGHT_BIT_ALU_WITH_FLAGS_DEFINES_SVH

// Clocked assertion, off while reset is asserted.
`define EALU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Signal must hold its value across a stalled cycle of a stream port.
`define EALU_ASSERT_HOLD(lbl, vld, rdy, sig, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (vld && !rdy) |=> $stable(sig)) else $error(msg);

`endif

// ===== rtl/ealu_pkg.sv =====
// Shared operation codes, widths and flag type for the eight-bit ALU.
package ealu_pkg;

  localparam int unsigned KindW   = 5;
  localparam int unsigned WordW   = 16;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned IdxW    = 3;
  localparam int unsigned InDataW  = 40;  // 35 used bits padded to bytes
  localparam int unsigned OutDataW = 24;  // 20 used bits padded to bytes

  localparam logic [KindW-1:0] OpInc8  = 5'd0;
  localparam logic [KindW-1:0] OpDec8  = 5'd1;
  localparam logic [KindW-1:0] OpInc16 = 5'd2;
  localparam logic [KindW-1:0] OpDec16 = 5'd3;
  localparam logic [KindW-1:0] OpAdd   = 5'd4;
  localparam logic [KindW-1:0] OpAdc   = 5'd5;
  localparam logic [KindW-1:0] OpSub   = 5'd6;
  localparam logic [KindW-1:0] OpSbc   = 5'd7;
  localparam logic [KindW-1:0] OpAnd   = 5'd8;
  localparam logic [KindW-1:0] OpOr    = 5'd9;
  localparam logic [KindW-1:0] OpXor   = 5'd10;
  localparam logic [KindW-1:0] OpCp    = 5'd11;
  localparam logic [KindW-1:0] OpCpl   = 5'd12;
  localparam logic [KindW-1:0] OpAdd16 = 5'd13;
  localparam logic [KindW-1:0] OpRla   = 5'd14;
  localparam logic [KindW-1:0] OpRra   = 5'd15;
  localparam logic [KindW-1:0] OpRlc   = 5'd16;
  localparam logic [KindW-1:0] OpRl    = 5'd17;
  localparam logic [KindW-1:0] OpRrc   = 5'd18;
  localparam logic [KindW-1:0] OpRr    = 5'd19;
  localparam logic [KindW-1:0] OpSla   = 5'd20;
  localparam logic [KindW-1:0] OpSra   = 5'd21;
  localparam logic [KindW-1:0] OpSwap  = 5'd22;
  localparam logic [KindW-1:0] OpSrl   = 5'd23;
  localparam logic [KindW-1:0] OpSet   = 5'd24;
  localparam logic [KindW-1:0] OpRes   = 5'd25;
  localparam logic [KindW-1:0] OpBit   = 5'd26;

  typedef struct packed {
    logic z;
    logic n;
    logic h;
    logic c;
  } flags_t;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [WordW-1:0] operand_a;
    logic [WordW-1:0] operand_b;
    logic [IdxW-1:0]  bit_index;
  } op_t;

endpackage

// ===== rtl/ealu_core.sv =====
// Combinational ALU datapath: one operation, result and next flags.
module ealu_core (
  input  ealu_pkg::op_t                 op_i,
  input  ealu_pkg::flags_t              flags_i,
  output logic [ealu_pkg::WordW-1:0]    result_o,
  output ealu_pkg::flags_t              flags_o
);

  logic [7:0]  a, b, bmask;
  logic        cin;
  logic [8:0]  add9, sub9;
  logic [4:0]  addh, subh;
  logic [16:0] add17;
  logic [12:0] add13;
  logic [7:0]  r8;

  assign a     = op_i.operand_a[7:0];
  assign b     = op_i.operand_b[7:0];
  assign bmask = 8'h01 << op_i.bit_index;

  // carry in used only by adc/sbc; rotates read flags_i.c directly
  assign cin = ((op_i.kind == ealu_pkg::OpAdc) || (op_i.kind == ealu_pkg::OpSbc))
               ? flags_i.c : 1'b0;

  assign add9  = {1'b0, a} + {1'b0, b} + {8'd0, cin};
  assign addh  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cin};
  assign sub9  = {1'b0, a} - {1'b0, b} - {8'd0, cin};
  assign subh  = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, cin};
  assign add17 = {1'b0, op_i.operand_a} + {1'b0, op_i.operand_b};
  assign add13 = {1'b0, op_i.operand_a[11:0]} + {1'b0, op_i.operand_b[11:0]};

  always_comb begin
    flags_o  = flags_i;
    r8       = 8'd0;
    result_o = '0;
    unique case (op_i.kind)
      ealu_pkg::OpInc8: begin
        r8 = a + 8'd1;
        flags_o.z = (r8 == 8'd0);
        flags_o.n = 1'b0;
        flags_o.h = (a[3:0] == 4'hF);
      end
      ealu_pkg::OpDec8: begin
        r8 = a - 8'd1;
        flags_o.z = (r8 == 8'd0);
        flags_o.n = 1'b1;
        flags_o.h = (a[3:0] == 4'h0);
      end
      ealu_pkg::OpAdd, ealu_pkg::OpAdc: begin
        r8 = add9[7:0];
        flags_o = '{z: (r8 == 8'd0), n: 1'b0, h: addh[4], c: add9[8]};
      end
      ealu_pkg::OpSub, ealu_pkg::OpSbc, ealu_pkg::OpCp: begin
        // cp keeps operand a as result, flags as for sub
        r8 = (op_i.kind == ealu_pkg::OpCp) ? a : sub9[7:0];
        flags_o = '{z: (sub9[7:0] == 8'd0), n: 1'b1, h: subh[4], c: sub9[8]};
      end
      ealu_pkg::OpAnd: begin
        r8 = a & b;
        flags_o = '{z: (r8 == 8'd0), n: 1'b0, h: 1'b1, c: 1'b0};
      end
      ealu_pkg::OpOr: begin
        r8 = a | b;
        flags_o = '{z: (r8 == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      ealu_pkg::OpXor: begin
        r8 = a ^ b;
        flags_o = '{z: (r8 == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      ealu_pkg::OpCpl: begin
        r8 = ~a;
        flags_o.n = 1'b1;
        flags_o.h = 1'b1;
      end
      ealu_pkg::OpRla, ealu_pkg::OpRl: begin
        r8 = {a[6:0], flags_i.c};
        flags_o = '{z: (op_i.kind == ealu_pkg::OpRl) && (r8 == 8'd0),
                    n: 1'b0, h: 1'b0, c: a[7]};
      end
      ealu_pkg::OpRra, ealu_pkg::OpRr: begin
        r8 = {flags_i.c, a[7:1]};
        flags_o = '{z: (op_i.kind == ealu_pkg::OpRr) && (r8 == 8'd0),
                    n: 1'b0, h: 1'b0, c: a[0]};
      end
      ealu_pkg::OpRlc: begin
        r8 = {a[6:0], a[7]};
        flags_o = '{z: (r8 == 8'd0), n: 1'b0, h: 1'b0, c: a[7]};
      end
      ealu_pkg::OpRrc: begin
        r8 = {a[0], a[7:1]};
        flags_o = '{z: (r8 == 8'd0), n: 1'b0, h: 1'b0, c: a[0]};
      end
      ealu_pkg::OpSla: begin
        r8 = {a[6:0], 1'b0};
        flags_o = '{z: (r8 == 8'd0), n: 1'b0, h: 1'b0, c: a[7]};
      end
      ealu_pkg::OpSra: begin
        r8 = {a[7], a[7:1]};
        flags_o = '{z: (r8 == 8'd0), n: 1'b0, h: 1'b0, c: a[0]};
      end
      ealu_pkg::OpSwap: begin
        r8 = {a[3:0], a[7:4]};
        flags_o = '{z: (r8 == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      ealu_pkg::OpSrl: begin
        r8 = {1'b0, a[7:1]};
        flags_o = '{z: (r8 == 8'd0), n: 1'b0, h: 1'b0, c: a[0]};
      end
      ealu_pkg::OpSet: r8 = a | bmask;
      ealu_pkg::OpRes: r8 = a & ~bmask;
      ealu_pkg::OpBit: begin
        r8 = a;
        flags_o.z = ((a & bmask) == 8'd0);
        flags_o.n = 1'b0;
        flags_o.h = 1'b1;
      end
      default: r8 = 8'd0;  // undefined codes and 16-bit ops
    endcase

    // 16-bit ops bypass the byte path
    unique case (op_i.kind)
      ealu_pkg::OpInc16: result_o = op_i.operand_a + 16'd1;
      ealu_pkg::OpDec16: result_o = op_i.operand_a - 16'd1;
      ealu_pkg::OpAdd16: begin
        result_o  = add17[15:0];
        flags_o.n = 1'b0;
        flags_o.h = add13[12];
        flags_o.c = add17[16];
      end
      default: result_o = {8'd0, r8};
    endcase
  end

endmodule

// ===== rtl/eight_bit_alu_with_flags.sv =====
// Top level of the eight-bit ALU with Z/N/H/C flags and stream ports.
// Datapath: an input register, then the ALU feeds the result register.
// Throughput: one word per cycle while m_axis_tready is high; the flag register is written in the same
//   edge that loads the result register, so the next op sees fresh flags.
// Reset: rst_ni async active low clears both valid bits and all flags.
module eight_bit_alu_with_flags (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // tdata: [15:0] operand_a, [31:16] operand_b, [34:32] bit_index, [39:35] zero
  input  logic [ealu_pkg::InDataW-1:0]     s_axis_tdata,
  // tuser: [4:0] kind
  input  logic [ealu_pkg::KindW-1:0]       s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // tdata: [15:0] result, [16] zero_flag, [17] subtract_flag,
  //        [18] half_carry_flag, [19] carry_flag, [23:20] zero
  output logic [ealu_pkg::OutDataW-1:0]    m_axis_tdata
);

  // input stage
  logic             in_vld_q, in_vld_d;
  ealu_pkg::op_t    in_op_q;
  logic             in_load;

  // result stage (output register)
  logic                         out_vld_q, out_vld_d;
  logic [ealu_pkg::WordW-1:0]   out_res_q;
  ealu_pkg::flags_t             out_flg_q;

  // architectural flags
  ealu_pkg::flags_t flags_q, flags_d;

  logic [ealu_pkg::WordW-1:0] alu_res;
  ealu_pkg::flags_t           alu_flg;
  logic                       advance;

  // input stage moves on whenever the result register is free or draining
  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;
  assign in_load       = s_axis_tvalid && s_axis_tready;

  assign in_vld_d  = in_load || (in_vld_q && !advance);
  assign out_vld_d = advance || (out_vld_q && !m_axis_tready);
  assign flags_d   = advance ? alu_flg : flags_q;

  ealu_core u_core (
    .op_i     (in_op_q),
    .flags_i  (flags_q),
    .result_o (alu_res),
    .flags_o  (alu_flg)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      flags_q   <= '0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      flags_q   <= flags_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_load) begin
      in_op_q.kind      <= s_axis_tuser;
      in_op_q.operand_a <= s_axis_tdata[15:0];
      in_op_q.operand_b <= s_axis_tdata[31:16];
      in_op_q.bit_index <= s_axis_tdata[34:32];
    end
    if (advance) begin
      out_res_q <= alu_res;
      out_flg_q <= alu_flg;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {4'd0, out_flg_q.c, out_flg_q.h, out_flg_q.n, out_flg_q.z,
                          out_res_q};

endmodule

// ===== rtl/ealu_checker.sv =====
// Port-level checker for the eight-bit ALU, bound to the top level.
`include "eight_bit_alu_with_flags_defines.svh"

module ealu_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [ealu_pkg::OutDataW-1:0] m_axis_tdata
);

  logic s_acc;
  assign s_acc = s_axis_tvalid && s_axis_tready;

  // empty result register must never block the input side
  `EALU_ASSERT(a_ready_when_empty, !m_axis_tvalid |-> s_axis_tready, "input stalled")
  // accepted word passes the input register into the result register if the sink is ready
  `EALU_ASSERT(a_latency, (s_acc ##1 m_axis_tready) |=> m_axis_tvalid, "word missing")
  `EALU_ASSERT(a_valid_hold, (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid, "valid dropped")
  `EALU_ASSERT_HOLD(a_data_hold, m_axis_tvalid, m_axis_tready, m_axis_tdata, "data changed")

endmodule

bind eight_bit_alu_with_flags ealu_checker u_ealu_checker (.*);
